// File: hw/rtl/cdq_pkg.sv
// Shared operation and status codes for the circular deque.
package cdq_pkg;

  localparam int WORD_W  = 32;
  localparam int TOTAL_W = 4;

  typedef enum logic [1:0] {
    OP_PUSH_FRONT = 2'd0,
    OP_PUSH_REAR  = 2'd1,
    OP_POP_FRONT  = 2'd2,
    OP_POP_REAR   = 2'd3
  } cdq_opcode_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } cdq_status_t;

  typedef struct packed {
    logic        pop_ok;
    cdq_status_t status;
  } cdq_resp_t;

endpackage

// File: hw/rtl/cdq_mem.sv
// Slot store: synchronous memory with one write and one registered read port.
module cdq_mem #(
  parameter int DEPTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [AW-1:0]             wr_addr,
  input  logic [cdq_pkg::WORD_W-1:0] wr_data,
  input  logic                      rd_en,
  input  logic [AW-1:0]             rd_addr,
  output logic [cdq_pkg::WORD_W-1:0] rd_data
);
  import cdq_pkg::*;

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: hw/rtl/cdq_ctrl.sv
// Head, tail and count bookkeeping; issues the slot access for each operation.
module cdq_ctrl #(
  parameter int DEPTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                go,
  input  logic [1:0]          opcode,
  output logic                wr_en,
  output logic [AW-1:0]       wr_addr,
  output logic                rd_en,
  output logic [AW-1:0]       rd_addr,
  output logic [CW-1:0]       count,
  output cdq_pkg::cdq_resp_t  resp
);
  import cdq_pkg::*;

  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  logic [AW-1:0] head_r, head_nxt;
  logic [AW-1:0] tail_r, tail_nxt;
  logic [CW-1:0] count_r, count_nxt;
  cdq_resp_t     resp_r, resp_nxt;
  logic          full, empty;

  function automatic logic [AW-1:0] wrap_next(input logic [AW-1:0] i);
    return (i == LAST) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [AW-1:0] wrap_prev(input logic [AW-1:0] i);
    return (i == '0) ? LAST : i - 1'b1;
  endfunction

  assign full  = (count_r == CW'(DEPTH));
  assign empty = (count_r == '0);

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    resp_nxt  = resp_r;
    wr_en     = 1'b0;
    wr_addr   = tail_r;
    rd_en     = 1'b0;
    rd_addr   = head_r;
    if (go) begin
      resp_nxt = '{pop_ok: 1'b0, status: ST_DONE};
      case (cdq_opcode_t'(opcode))
        OP_PUSH_FRONT: begin
          if (full) begin
            resp_nxt.status = ST_FULL;
          end else begin
            head_nxt  = wrap_prev(head_r);
            wr_en     = 1'b1;
            wr_addr   = wrap_prev(head_r);
            count_nxt = count_r + 1'b1;
          end
        end
        OP_PUSH_REAR: begin
          if (full) begin
            resp_nxt.status = ST_FULL;
          end else begin
            wr_en     = 1'b1;
            wr_addr   = tail_r;
            tail_nxt  = wrap_next(tail_r);
            count_nxt = count_r + 1'b1;
          end
        end
        OP_POP_FRONT: begin
          if (empty) begin
            resp_nxt.status = ST_EMPTY;
          end else begin
            rd_en           = 1'b1;
            rd_addr         = head_r;
            head_nxt        = wrap_next(head_r);
            count_nxt       = count_r - 1'b1;
            resp_nxt.pop_ok = 1'b1;
          end
        end
        default: begin
          if (empty) begin
            resp_nxt.status = ST_EMPTY;
          end else begin
            rd_en           = 1'b1;
            rd_addr         = wrap_prev(tail_r);
            tail_nxt        = wrap_prev(tail_r);
            count_nxt       = count_r - 1'b1;
            resp_nxt.pop_ok = 1'b1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
    resp_r <= resp_nxt;
  end

  assign count = count_r;
  assign resp  = resp_r;

endmodule

// File: hw/rtl/circular_deque.sv
// Circular deque: top level with handshake, slot memory and result register.
//
// Double-ended queue of DEPTH signed 32-bit words held in a one-port-pair
// synchronous memory. Each input word is one operation (push front, push
// rear, pop front, pop rear) and yields exactly one result word with the
// popped value (zero unless a pop succeeded), a status code and the entry
// count after the operation, masked to 4 bits. In the accept cycle
// the pointers are updated and the slot access is issued, and the
// next cycle captures the memory's registered read data into the output
// register. Only one operation is in flight at a time: no new one is taken
// until its result is registered, and a new operation is taken in the same
// cycle the previous result is taken. Storage needs no clear after reset: a
// pop only reads slots filled by an earlier push.
module circular_deque #(
  parameter int DEPTH = 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [1:0]                       in_opcode,
  input  logic signed [cdq_pkg::WORD_W-1:0] in_push_value,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [cdq_pkg::WORD_W-1:0] out_pop_value,
  output logic [1:0]                       out_status,
  output logic [cdq_pkg::TOTAL_W-1:0]      out_entry_total
);
  import cdq_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic              go;
  logic              pend_r;
  logic              out_valid_r;
  logic [WORD_W-1:0] pop_value_r;
  logic [1:0]        status_r;
  logic [TOTAL_W-1:0] total_r;

  logic              wr_en, rd_en;
  logic [AW-1:0]     wr_addr, rd_addr;
  logic [WORD_W-1:0] rd_data;
  logic [CW-1:0]     count;
  cdq_resp_t         resp;
  logic [CW+TOTAL_W-1:0] count_ext;

  assign in_ready = !pend_r && (!out_valid_r || out_ready);
  assign go       = in_valid && in_ready;

  cdq_ctrl #(.DEPTH(DEPTH), .AW(AW), .CW(CW)) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .go      (go),
    .opcode  (in_opcode),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .count   (count),
    .resp    (resp)
  );

  cdq_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_push_value),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // mask the count to the result field width
  assign count_ext = {{TOTAL_W{1'b0}}, count};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pend_r <= go;
      if (pend_r) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (pend_r) begin
      pop_value_r <= resp.pop_ok ? rd_data : '0;
      status_r    <= resp.status;
      total_r     <= count_ext[TOTAL_W-1:0];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pop_value   = pop_value_r;
  assign out_status      = status_r;
  assign out_entry_total = total_r;

endmodule

// File: hw/rtl/cdq_checker.sv
// Port-level checks for the circular deque, bound to the top level.
module cdq_checker #(
  parameter int DEPTH = 8
) (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic signed [cdq_pkg::WORD_W-1:0] out_pop_value,
  input logic [1:0]                       out_status,
  input logic [cdq_pkg::TOTAL_W-1:0]      out_entry_total
);
  import cdq_pkg::*;

  localparam logic [TOTAL_W-1:0] FULL_TOTAL = TOTAL_W'(DEPTH);

  // a refused operation always returns a zero popped value
  a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_DONE) |-> out_pop_value == '0)
    else $error("refused operation returned a nonzero word");

  a_full_total: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_FULL) |-> out_entry_total == FULL_TOTAL)
    else $error("full refusal with wrong entry total");

  a_empty_total: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_EMPTY) |-> out_entry_total == '0)
    else $error("empty refusal with nonzero entry total");

  // one operation in flight at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second word accepted while an operation is in flight");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pop_value) &&
      $stable(out_status) && $stable(out_entry_total))
    else $error("stalled result word changed");

endmodule

bind circular_deque cdq_checker #(.DEPTH(DEPTH)) u_cdq_checker (.*);

// File: dv/circular_deque_test.sv
// Self-checking testbench for the circular deque: directed table plus random traffic.
`timescale 1ns / 100ps

module circular_deque_test;
  import cdq_pkg::*;

  localparam int DEPTH       = 8;
  localparam int STALL_LIMIT = 2000;
  localparam int RAND_WORDS  = 400;
  localparam int CALM_WORDS  = 80;

  typedef struct {
    logic [WORD_W-1:0]  pop_value;
    cdq_status_t        status;
    logic [TOTAL_W-1:0] entry_total;
  } deque_result_t;

  typedef struct {
    cdq_opcode_t        op;
    logic [WORD_W-1:0]  value;
    bit                 fixed;
    logic [WORD_W-1:0]  pop_value;
    cdq_status_t        status;
    logic [TOTAL_W-1:0] entry_total;
  } op_row_t;

  logic                      clk;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_ready;
  logic [1:0]                in_opcode;
  logic signed [WORD_W-1:0]  in_push_value;
  logic                      out_valid;
  logic                      out_ready;
  logic signed [WORD_W-1:0]  out_pop_value;
  logic [1:0]                out_status;
  logic [TOTAL_W-1:0]        out_entry_total;

  // Shadow deque state
  logic [WORD_W-1:0] shadow_slots [DEPTH];
  int unsigned       shadow_head;
  int unsigned       shadow_tail;
  int unsigned       shadow_fill;

  deque_result_t pending_results [$];
  op_row_t       directed_ops [$];
  int            err_count;
  int            quiet_cycles;
  int            rx_stall_left;
  bit            idling;

  circular_deque #(.DEPTH(DEPTH)) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_opcode       (in_opcode),
    .in_push_value   (in_push_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_pop_value   (out_pop_value),
    .out_status      (out_status),
    .out_entry_total (out_entry_total)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  task automatic report_mismatch(input string msg);
    err_count++;
    $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  // Apply one operation to the shadow deque and return what the block should answer.
  function automatic deque_result_t apply_deque_op(cdq_opcode_t op, logic [WORD_W-1:0] word);
    deque_result_t res;
    res.pop_value = '0;
    res.status    = ST_DONE;
    case (op)
      OP_PUSH_FRONT: begin
        if (shadow_fill >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          shadow_head = (shadow_head + DEPTH - 1) % DEPTH;
          shadow_slots[shadow_head] = word;
          shadow_fill++;
        end
      end
      OP_PUSH_REAR: begin
        if (shadow_fill >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          shadow_slots[shadow_tail] = word;
          shadow_tail = (shadow_tail + 1) % DEPTH;
          shadow_fill++;
        end
      end
      OP_POP_FRONT: begin
        if (shadow_fill == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.pop_value = shadow_slots[shadow_head];
          shadow_head = (shadow_head + 1) % DEPTH;
          shadow_fill--;
        end
      end
      default: begin
        if (shadow_fill == 0) begin
          res.status = ST_EMPTY;
        end else begin
          shadow_tail = (shadow_tail + DEPTH - 1) % DEPTH;
          res.pop_value = shadow_slots[shadow_tail];
          shadow_fill--;
        end
      end
    endcase
    res.entry_total = shadow_fill[TOTAL_W-1:0];
    return res;
  endfunction

  // Present one word, hold it until taken, then log the expected result.
  task automatic send_word(input op_row_t row);
    deque_result_t res;
    if (idling && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_opcode     <= row.op;
    in_push_value <= row.value;
    do @(posedge clk); while (!in_ready);
    res = apply_deque_op(row.op, row.value);
    if (row.fixed) begin
      res.pop_value   = row.pop_value;
      res.status      = row.status;
      res.entry_total = row.entry_total;
    end
    pending_results.push_back(res);
  endtask

  // Result side: random stall bursts while idling is on.
  always @(posedge clk) begin
    if (rx_stall_left > 0) begin
      rx_stall_left = rx_stall_left - 1;
      out_ready <= 1'b0;
    end else if (idling && $urandom_range(0, 9) == 0) begin
      rx_stall_left = $urandom_range(1, 18) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    deque_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result value=%h status=%0d total=%0d",
                                  out_pop_value, out_status, out_entry_total));
      end else begin
        want = pending_results.pop_front();
        if (out_pop_value !== want.pop_value)
          report_mismatch($sformatf("pop_value got %h want %h", out_pop_value, want.pop_value));
        if (out_status !== want.status)
          report_mismatch($sformatf("status got %0d want %0d", out_status, want.status));
        if (out_entry_total !== want.entry_total)
          report_mismatch($sformatf("entry_total got %0d want %0d",
                                    out_entry_total, want.entry_total));
      end
    end
  end

  // Watchdog: count cycles with no word moving on either side.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    op_row_t     row;
    int unsigned push_pct;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_opcode     = OP_PUSH_FRONT;
    in_push_value = '0;
    out_ready     = 1'b0;
    err_count     = 0;
    quiet_cycles  = 0;
    rx_stall_left = 0;
    idling        = 1'b1;
    shadow_head   = 0;
    shadow_tail   = 0;
    shadow_fill   = 0;
    push_pct      = 50;
    foreach (shadow_slots[i]) shadow_slots[i] = '0;

    // op, value, fixed, expected pop_value, status, entry_total
    directed_ops.push_back('{OP_POP_FRONT,  32'h0000_0000, 1'b1, 32'h0, ST_EMPTY, 4'd0});
    directed_ops.push_back('{OP_POP_REAR,   32'hFFFF_FFFF, 1'b1, 32'h0, ST_EMPTY, 4'd0});
    directed_ops.push_back('{OP_PUSH_REAR,  32'h7FFF_FFFF, 1'b1, 32'h0, ST_DONE,  4'd1});
    directed_ops.push_back('{OP_PUSH_FRONT, 32'h8000_0000, 1'b1, 32'h0, ST_DONE,  4'd2});
    directed_ops.push_back('{OP_POP_REAR,   32'h0000_0000, 1'b1, 32'h7FFF_FFFF, ST_DONE, 4'd1});
    directed_ops.push_back('{OP_POP_FRONT,  32'h1234_5678, 1'b1, 32'h8000_0000, ST_DONE, 4'd0});
    directed_ops.push_back('{OP_PUSH_FRONT, 32'hFFFF_FFFF, 1'b1, 32'h0, ST_DONE,  4'd1});
    directed_ops.push_back('{OP_PUSH_FRONT, 32'h0000_0000, 1'b0, 32'h0, ST_DONE,  4'd0});
    directed_ops.push_back('{OP_PUSH_REAR,  32'h0000_0001, 1'b0, 32'h0, ST_DONE,  4'd0});
    directed_ops.push_back('{OP_PUSH_REAR,  32'hA5A5_A5A5, 1'b0, 32'h0, ST_DONE,  4'd0});
    directed_ops.push_back('{OP_PUSH_FRONT, 32'h5A5A_5A5A, 1'b0, 32'h0, ST_DONE,  4'd0});
    directed_ops.push_back('{OP_PUSH_REAR,  32'h1234_5678, 1'b0, 32'h0, ST_DONE,  4'd0});
    directed_ops.push_back('{OP_PUSH_FRONT, 32'h8000_0001, 1'b0, 32'h0, ST_DONE,  4'd0});
    directed_ops.push_back('{OP_PUSH_REAR,  32'h7FFF_FFFE, 1'b0, 32'h0, ST_DONE,  4'd0});
    directed_ops.push_back('{OP_PUSH_FRONT, 32'h0000_0001, 1'b1, 32'h0, ST_FULL,  4'd8});
    directed_ops.push_back('{OP_PUSH_REAR,  32'hFFFF_FFFE, 1'b1, 32'h0, ST_FULL,  4'd8});
    directed_ops.push_back('{OP_POP_FRONT,  32'hDEAD_BEEF, 1'b0, 32'h0, ST_DONE,  4'd0});
    directed_ops.push_back('{OP_POP_REAR,   32'h0000_0000, 1'b0, 32'h0, ST_DONE,  4'd0});
    directed_ops.push_back('{OP_POP_REAR,   32'h0000_0000, 1'b0, 32'h0, ST_DONE,  4'd0});
    directed_ops.push_back('{OP_POP_FRONT,  32'h0000_0000, 1'b0, 32'h0, ST_DONE,  4'd0});
    directed_ops.push_back('{OP_POP_REAR,   32'h0000_0000, 1'b0, 32'h0, ST_DONE,  4'd0});
    directed_ops.push_back('{OP_POP_FRONT,  32'h0000_0000, 1'b0, 32'h0, ST_DONE,  4'd0});
    directed_ops.push_back('{OP_POP_FRONT,  32'h0000_0000, 1'b0, 32'h0, ST_DONE,  4'd0});
    directed_ops.push_back('{OP_POP_REAR,   32'h0000_0000, 1'b0, 32'h0, ST_DONE,  4'd0});
    directed_ops.push_back('{OP_POP_REAR,   32'hFFFF_FFFF, 1'b1, 32'h0, ST_EMPTY, 4'd0});

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_ops[i]) send_word(directed_ops[i]);

    for (int n = 0; n < RAND_WORDS; n++) begin
      // Swing the push/pop mix so the deque keeps hitting full and empty.
      if (n % 25 == 0) begin
        case ($urandom_range(0, 2))
          0:       push_pct = 15;
          1:       push_pct = 50;
          default: push_pct = 85;
        endcase
      end
      idling = (n < 150) || (n >= 200 && n < RAND_WORDS - CALM_WORDS);
      if (n == 250) begin
        // Hold the sender until every outstanding result has drained.
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        @(posedge clk);
      end
      if ($urandom_range(0, 99) < push_pct)
        row.op = $urandom_range(0, 1) ? OP_PUSH_REAR : OP_PUSH_FRONT;
      else
        row.op = $urandom_range(0, 1) ? OP_POP_REAR : OP_POP_FRONT;
      case ($urandom_range(0, 7))
        0:       row.value = 32'h8000_0000;
        1:       row.value = 32'h7FFF_FFFF;
        2:       row.value = 32'hFFFF_FFFF;
        3:       row.value = 32'h0000_0000;
        default: row.value = $urandom;
      endcase
      row.fixed = 1'b0;
      send_word(row);
    end

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (err_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: circular_deque.f
hw/rtl/cdq_pkg.sv
hw/rtl/cdq_mem.sv
hw/rtl/cdq_ctrl.sv
hw/rtl/circular_deque.sv
hw/rtl/cdq_checker.sv
dv/circular_deque_test.sv
